// ===== design/dnd_pkg.sv =====
// Shared types and constants for the DNS name decompressor.
`default_nettype none

package dnd_pkg;

  localparam int ADDR_W = 12;
  localparam int LEN_W  = 13;
  localparam int POS_W  = 14;
  localparam int CHUNK_CHARS = 8;
  localparam int CHARS_W = 8 * CHUNK_CHARS;

  localparam logic [7:0] LABEL_LIMIT = 8'd64;
  localparam logic [7:0] DOT_CHAR    = 8'h2E;

  localparam logic [7:0] MAX_HOPS_RST  = 8'd16;
  localparam logic [7:0] MAX_NAME_RST  = 8'd255;

  localparam logic REG_MAX_HOPS = 1'b0;
  localparam logic REG_MAX_NAME = 1'b1;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_CAP = 2'd2,
    ST_HOP = 2'd3
  } dnd_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_HEAD,
    S_PTR,
    S_LCHK,
    S_LBYTE,
    S_FLUSH,
    S_EMIT,
    S_SHOW
  } dnd_state_e;

  typedef struct packed {
    logic        in_ready;
    logic        start;
    logic        msg_rd;
    logic        msg_rd_next;
    logic        pos_inc;
    logic        label_begin;
    logic        put_dot;
    logic        put_char;
    logic        hop;
    logic        ptr_load;
    logic        finish;
    dnd_status_e fin_status;
    logic        flush;
    logic        name_rd;
    logic        out_load;
    logic        k_inc;
  } dnd_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic byte_zero;
    logic byte_label;
    logic pos_ge_len;
    logic ptr_cut;
    logic hop_lim;
    logic cap_full;
    logic need_dot;
    logic rem_zero;
    logic chunk_last;
    logic out_free;
  } dnd_stat_t;

endpackage

`default_nettype wire

// ===== design/dnd_in_if.sv =====
// Input channel: load and decode items.
`default_nettype none

interface dnd_in_if import dnd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] load_addr;
  logic [7:0]        load_byte;
  logic [ADDR_W-1:0] start_pos;
  logic [LEN_W-1:0]  msg_len;

  modport source (output valid, mode, load_addr, load_byte, start_pos, msg_len,
                  input ready);
  modport sink   (input valid, mode, load_addr, load_byte, start_pos, msg_len,
                  output ready);
endinterface

`default_nettype wire

// ===== design/dnd_out_if.sv =====
// Output channel: name chunks with end offset and status.
`default_nettype none

interface dnd_out_if import dnd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CHARS_W-1:0] chars;
  logic [3:0]         char_count;
  logic               last;
  logic [LEN_W-1:0]   end_pos;
  logic [1:0]         status;

  modport source (output valid, chars, char_count, last, end_pos, status,
                  input ready);
  modport sink   (input valid, chars, char_count, last, end_pos, status,
                  output ready);
endinterface

`default_nettype wire

// ===== design/dnd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/dnd_ctrl.sv =====
// Controller state machine for the label walk and chunk output.
`default_nettype none

module dnd_ctrl import dnd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire dnd_stat_t stat_i,
  output dnd_cmd_t       cmd_o
);

  dnd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.in_valid && stat_i.in_mode) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = stat_i.pos_ge_len ? S_FLUSH : S_HEAD;
      end
      S_HEAD: begin
        if (stat_i.byte_zero) begin
          state_d = S_FLUSH;
        end else if (stat_i.byte_label) begin
          state_d = (stat_i.need_dot && stat_i.cap_full) ? S_FLUSH : S_LCHK;
        end else begin
          state_d = (stat_i.ptr_cut || stat_i.hop_lim) ? S_FLUSH : S_PTR;
        end
      end
      S_PTR:   state_d = S_CHECK;
      S_LCHK: begin
        if (stat_i.rem_zero) begin
          state_d = S_CHECK;
        end else if (stat_i.pos_ge_len || stat_i.cap_full) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_LBYTE;
        end
      end
      S_LBYTE: state_d = S_LCHK;
      S_FLUSH: state_d = S_EMIT;
      S_EMIT:  state_d = S_SHOW;
      S_SHOW: begin
        if (stat_i.out_free) state_d = stat_i.chunk_last ? S_IDLE : S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.fin_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.start    = stat_i.in_valid && stat_i.in_mode;
      end
      S_CHECK: begin
        if (stat_i.pos_ge_len) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_LEN;
        end else begin
          cmd_o.msg_rd = 1'b1;
        end
      end
      S_HEAD: begin
        if (stat_i.byte_zero) begin
          cmd_o.pos_inc    = 1'b1;
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_OK;
        end else if (stat_i.byte_label) begin
          cmd_o.pos_inc = 1'b1;
          if (stat_i.need_dot && stat_i.cap_full) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_CAP;
          end else begin
            cmd_o.put_dot     = stat_i.need_dot;
            cmd_o.label_begin = 1'b1;
          end
        end else if (stat_i.ptr_cut) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_LEN;
        end else if (stat_i.hop_lim) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_HOP;
        end else begin
          cmd_o.hop         = 1'b1;
          cmd_o.msg_rd_next = 1'b1;
        end
      end
      S_PTR: cmd_o.ptr_load = 1'b1;
      S_LCHK: begin
        if (stat_i.rem_zero) begin
          cmd_o.finish = 1'b0;
        end else if (stat_i.pos_ge_len) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_LEN;
        end else if (stat_i.cap_full) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_CAP;
        end else begin
          cmd_o.msg_rd = 1'b1;
        end
      end
      S_LBYTE: begin
        cmd_o.put_char = 1'b1;
        cmd_o.pos_inc  = 1'b1;
      end
      S_FLUSH: cmd_o.flush   = 1'b1;
      S_EMIT:  cmd_o.name_rd = 1'b1;
      S_SHOW: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.k_inc    = stat_i.out_free && !stat_i.chunk_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/dnd_datapath.sv =====
// Datapath: message store, walk registers, name buffer and output register.
`default_nettype none

module dnd_datapath import dnd_pkg::*; #(
  parameter int MSG_BYTES = 4096,
  parameter int NAME_MAX  = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dnd_cmd_t   cmd_i,
  output dnd_stat_t       stat_o,
  input  wire logic [7:0] max_hops_i,
  input  wire logic [7:0] max_name_chars_i,
  dnd_in_if.sink          in_i,
  dnd_out_if.source       out_o
);

  localparam int MAW = $clog2(MSG_BYTES);
  localparam int NW  = (NAME_MAX + CHUNK_CHARS - 1) / CHUNK_CHARS;
  localparam int NWA = $clog2(NW);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [POS_W-1:0]   ret_q, ret_d;
  logic               jumped_q, jumped_d;
  logic               need_dot_q, need_dot_d;
  logic [7:0]         hops_q, hops_d;
  logic [7:0]         count_q, count_d;
  logic [7:0]         keep_q, keep_d;
  logic [5:0]         rem_q, rem_d;
  logic [5:0]         hi_q, hi_d;
  logic [CHARS_W-1:0] word_q, word_d;
  logic [NWA-1:0]     k_q, k_d;
  dnd_status_e        status_q, status_d;

  logic               out_valid_q, out_valid_d;
  logic [CHARS_W-1:0] out_chars_q;
  logic [3:0]         out_count_q;
  logic               out_last_q;
  logic [LEN_W-1:0]   out_end_q;
  dnd_status_e        out_status_q;

  logic               load_we;
  logic [31:0]        load_addr32;
  logic [31:0]        rd_pos32;
  logic [POS_W-1:0]   rd_pos;
  logic [7:0]         msg_byte;
  logic [LEN_W-1:0]   len_clamped;
  logic [7:0]         cap;
  logic               append;
  logic [7:0]         app_byte;
  logic [2:0]         idx;
  logic [CHARS_W-1:0] word_next;
  logic               name_we;
  logic [CHARS_W-1:0] name_wdata;
  logic [CHARS_W-1:0] name_word;
  logic [4:0]         lastk;
  logic               chunk_last;
  logic [7:0]         chunk_left;
  logic [3:0]         chunk_count;
  logic [CHARS_W-1:0] chunk_chars;
  logic               out_free;

  // message store
  assign load_addr32 = 32'(in_i.load_addr);
  assign load_we     = in_i.valid && cmd_i.in_ready && !in_i.mode &&
                       (load_addr32 < 32'(MSG_BYTES));
  assign rd_pos      = cmd_i.msg_rd_next ? (pos_q + POS_W'(1)) : pos_q;
  assign rd_pos32    = 32'(rd_pos);

  dnd_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_addr32[MAW-1:0]),
    .wdata_i (in_i.load_byte),
    .re_i    (cmd_i.msg_rd || cmd_i.msg_rd_next),
    .raddr_i (rd_pos32[MAW-1:0]),
    .rdata_o (msg_byte)
  );

  assign len_clamped = (32'(in_i.msg_len) > 32'(MSG_BYTES)) ? LEN_W'(MSG_BYTES)
                                                            : in_i.msg_len;
  assign cap = (32'(max_name_chars_i) > 32'(NAME_MAX)) ? 8'(NAME_MAX)
                                                       : max_name_chars_i;

  // name assembly
  assign append   = cmd_i.put_dot || cmd_i.put_char;
  assign app_byte = cmd_i.put_dot ? DOT_CHAR : msg_byte;
  assign idx      = count_q[2:0];

  always_comb begin
    word_next = (idx == 3'd0) ? '0 : word_q;
    word_next[8*idx +: 8] = app_byte;
  end

  assign name_we    = (append && idx == 3'd7) || (cmd_i.flush && idx != 3'd0);
  assign name_wdata = append ? word_next : word_q;

  dnd_ram #(.WIDTH(CHARS_W), .DEPTH(NW)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (count_q[NWA+2:3]),
    .wdata_i (name_wdata),
    .re_i    (cmd_i.name_rd),
    .raddr_i (k_q),
    .rdata_o (name_word)
  );

  // walk registers
  always_comb begin
    pos_d      = pos_q;
    len_d      = len_q;
    ret_d      = ret_q;
    jumped_d   = jumped_q;
    need_dot_d = need_dot_q;
    hops_d     = hops_q;
    count_d    = count_q;
    keep_d     = keep_q;
    rem_d      = rem_q;
    hi_d       = hi_q;
    word_d     = word_q;
    k_d        = k_q;
    status_d   = status_q;

    if (cmd_i.start) begin
      pos_d      = POS_W'(in_i.start_pos);
      len_d      = len_clamped;
      jumped_d   = 1'b0;
      need_dot_d = 1'b0;
      hops_d     = '0;
      count_d    = '0;
      keep_d     = '0;
      k_d        = '0;
    end else if (cmd_i.ptr_load) begin
      pos_d = {hi_q, msg_byte};
    end else if (cmd_i.pos_inc) begin
      pos_d = pos_q + POS_W'(1);
    end

    if (cmd_i.label_begin) begin
      rem_d      = msg_byte[5:0];
      need_dot_d = 1'b1;
    end else if (cmd_i.put_char) begin
      rem_d = rem_q - 6'd1;
    end

    if (append) begin
      count_d = count_q + 8'd1;
      word_d  = word_next;
      if (app_byte != DOT_CHAR) keep_d = count_q + 8'd1;
    end

    if (cmd_i.hop) begin
      hops_d = hops_q + 8'd1;
      hi_d   = msg_byte[5:0];
      if (!jumped_q) begin
        ret_d    = pos_q + POS_W'(2);
        jumped_d = 1'b1;
      end
    end

    if (cmd_i.finish) status_d = cmd_i.fin_status;
    if (cmd_i.k_inc) k_d = k_q + NWA'(1);
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    len_q      <= len_d;
    ret_q      <= ret_d;
    jumped_q   <= jumped_d;
    need_dot_q <= need_dot_d;
    hops_q     <= hops_d;
    count_q    <= count_d;
    keep_q     <= keep_d;
    rem_q      <= rem_d;
    hi_q       <= hi_d;
    word_q     <= word_d;
    k_q        <= k_d;
    status_q   <= status_d;
  end

  // chunk shaping
  assign lastk       = (keep_q == 8'd0) ? 5'd0 : 5'((keep_q - 8'd1) >> 3);
  assign chunk_last  = (5'(k_q) == lastk);
  assign chunk_left  = keep_q - {5'(k_q), 3'b000};
  assign chunk_count = chunk_last ? chunk_left[3:0] : 4'd8;

  always_comb begin
    for (int i = 0; i < CHUNK_CHARS; i++) begin
      chunk_chars[8*i +: 8] = (4'(i) < chunk_count) ? name_word[8*i +: 8] : 8'd0;
    end
  end

  // output register
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_chars_q  <= chunk_chars;
      out_count_q  <= chunk_count;
      out_last_q   <= chunk_last;
      out_end_q    <= chunk_last ? (jumped_q ? ret_q[LEN_W-1:0] : pos_q[LEN_W-1:0])
                                 : '0;
      out_status_q <= chunk_last ? status_q : ST_OK;
    end
  end

  assign in_i.ready       = cmd_i.in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.chars      = out_chars_q;
  assign out_o.char_count = out_count_q;
  assign out_o.last       = out_last_q;
  assign out_o.end_pos    = out_end_q;
  assign out_o.status     = out_status_q;

  assign stat_o.in_valid   = in_i.valid;
  assign stat_o.in_mode    = in_i.mode;
  assign stat_o.byte_zero  = (msg_byte == 8'd0);
  assign stat_o.byte_label = (msg_byte != 8'd0) && (msg_byte < LABEL_LIMIT);
  assign stat_o.pos_ge_len = (pos_q >= {1'b0, len_q});
  assign stat_o.ptr_cut    = ((15'(pos_q) + 15'd1) >= 15'(len_q));
  assign stat_o.hop_lim    = (hops_q >= max_hops_i);
  assign stat_o.cap_full   = (count_q >= cap);
  assign stat_o.need_dot   = need_dot_q;
  assign stat_o.rem_zero   = (rem_q == 6'd0);
  assign stat_o.chunk_last = chunk_last;
  assign stat_o.out_free   = out_free;

endmodule

`default_nettype wire

// ===== design/dns_name_decompressor.sv =====
// Top level of the DNS name decompressor: configuration registers and core.
//
// in_i carries load items (mode 0) and decode items (mode 1). A load item
// writes one byte into the message store; it yields no
// output. A decode item walks the encoded name from start_pos and returns the
// name in 8-character chunks on out_o, the last chunk marked by last and
// carrying end_pos and status.
// Decoding follows the message store's registered read: the item is taken,
// then the walk reads each terminator byte, label (length byte and closing
// check), label character and compression pointer in turn, or stops at the
// length; then the name buffer is flushed and the chunks are sent.
// Items are handled one at a time; in_i.ready is high only between decodes.
// The final chunk sits in the output register, so the next item is taken
// while it waits. When out_o.ready is low, chunk output holds.
// Reset clears the controller and output valid and sets max_hops to 16 and
// max_name_chars to 255; the message store is not cleared and must be loaded
// before it is decoded. Write registers over the APB port only while idle.
`default_nettype none

module dns_name_decompressor import dnd_pkg::*; #(
  parameter int MSG_BYTES = 4096,
  parameter int NAME_MAX  = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  dnd_in_if.sink           in_i,
  dnd_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [7:0] max_hops_q, max_hops_d;
  logic [7:0] max_name_q, max_name_d;
  logic       cfg_we;
  dnd_cmd_t   cmd;
  dnd_stat_t  stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    max_hops_d = max_hops_q;
    max_name_d = max_name_q;
    if (cfg_we) begin
      unique case (paddr[2])
        REG_MAX_HOPS: max_hops_d = pwdata[7:0];
        REG_MAX_NAME: max_name_d = pwdata[7:0];
        default:      max_hops_d = max_hops_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_hops_q <= MAX_HOPS_RST;
      max_name_q <= MAX_NAME_RST;
    end else begin
      max_hops_q <= max_hops_d;
      max_name_q <= max_name_d;
    end
  end

  assign prdata = (paddr[2] == REG_MAX_NAME) ? {24'd0, max_name_q} : {24'd0, max_hops_q};

  dnd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  dnd_datapath #(.MSG_BYTES(MSG_BYTES), .NAME_MAX(NAME_MAX)) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .max_hops_i       (max_hops_q),
    .max_name_chars_i (max_name_q),
    .in_i             (in_i),
    .out_o            (out_o)
  );

endmodule

`default_nettype wire

// ===== verif/dnd_name_checker.sv =====
// Checker for the DNS name decompressor: predicts name chunks and compares them.
`timescale 1ns / 1ps

module dnd_name_checker import dnd_pkg::*; #(
  parameter int STORE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dnd_in_if           items_in,
  dnd_out_if          chunks_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [CHARS_W-1:0] chars;
    logic [3:0]         char_count;
    logic               last;
    logic [LEN_W-1:0]   end_pos;
    dnd_status_e        status;
  } name_chunk_t;

  logic [7:0]  msg_store [STORE_BYTES];
  logic [7:0]  hop_limit;
  logic [7:0]  name_cap;
  name_chunk_t expected_chunks [$];

  function automatic void decode_name(input int unsigned start, input int unsigned span);
    logic [7:0]  name_buf [256];
    logic [7:0]  hdr;
    int unsigned lim, pos, cnt, ret, hops, nchunks, j, k, i;
    bit          jumped, need_dot, done;
    dnd_status_e stop;
    name_chunk_t chunk;
    lim = (span > STORE_BYTES) ? STORE_BYTES : span;
    pos = start;
    cnt = 0;
    ret = 0;
    hops = 0;
    jumped = 1'b0;
    need_dot = 1'b0;
    done = 1'b0;
    stop = ST_OK;
    while (!done) begin
      if (pos >= lim) begin
        stop = ST_LEN;
        done = 1'b1;
      end else begin
        hdr = msg_store[pos];
        if (hdr == 8'h00) begin
          pos++;
          stop = ST_OK;
          done = 1'b1;
        end else if (hdr < LABEL_LIMIT) begin
          pos++;
          if (need_dot && cnt >= name_cap) begin
            stop = ST_CAP;
            done = 1'b1;
          end else begin
            if (need_dot) begin
              name_buf[cnt] = DOT_CHAR;
              cnt++;
            end
            for (j = 0; j < hdr && !done; j++) begin
              if (pos >= lim) begin
                stop = ST_LEN;
                done = 1'b1;
              end else if (cnt >= name_cap) begin
                stop = ST_CAP;
                done = 1'b1;
              end else begin
                name_buf[cnt] = msg_store[pos];
                cnt++;
                pos++;
              end
            end
            need_dot = 1'b1;
          end
        end else if (pos + 1 >= lim) begin
          stop = ST_LEN;
          done = 1'b1;
        end else if (hops >= hop_limit) begin
          stop = ST_HOP;
          done = 1'b1;
        end else begin
          hops++;
          if (!jumped) begin
            ret = pos + 2;
            jumped = 1'b1;
          end
          pos = {18'd0, hdr[5:0], msg_store[pos + 1]};
        end
      end
    end

    // drop trailing dots
    while (cnt > 0 && name_buf[cnt - 1] == DOT_CHAR) cnt--;

    nchunks = (cnt + CHUNK_CHARS - 1) / CHUNK_CHARS;
    if (nchunks == 0) nchunks = 1;
    for (k = 0; k < nchunks; k++) begin
      chunk = '0;
      for (i = 0; i < CHUNK_CHARS; i++) begin
        if (k * CHUNK_CHARS + i < cnt) begin
          chunk.chars[8*i +: 8] = name_buf[k * CHUNK_CHARS + i];
          chunk.char_count = chunk.char_count + 4'd1;
        end
      end
      chunk.last = (k + 1 == nchunks);
      if (chunk.last) begin
        chunk.end_pos = LEN_W'(jumped ? ret : pos);
        chunk.status = stop;
      end
      expected_chunks.push_back(chunk);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    name_chunk_t got, want;
    if (!rst_ni) begin
      hop_limit <= MAX_HOPS_RST;
      name_cap <= MAX_NAME_RST;
      expected_chunks.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (chunks_out.valid && chunks_out.ready) begin
        got.chars = chunks_out.chars;
        got.char_count = chunks_out.char_count;
        got.last = chunks_out.last;
        got.end_pos = chunks_out.end_pos;
        got.status = dnd_status_e'(chunks_out.status);
        if (expected_chunks.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected chunk chars=%h count=%0d last=%0b end=%0d status=%0d",
                     $realtime, got.chars, got.char_count, got.last, got.end_pos,
                     got.status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_chunks.pop_front();
          if (got.chars !== want.chars || got.char_count !== want.char_count ||
              got.last !== want.last || got.end_pos !== want.end_pos ||
              got.status !== want.status) begin
            if (fail_count < 10)
              $display({"%0t: chunk mismatch: expected chars=%h count=%0d last=%0b end=%0d",
                        " status=%0d, got chars=%h count=%0d last=%0b end=%0d status=%0d"},
                       $realtime, want.chars, want.char_count, want.last, want.end_pos,
                       want.status, got.chars, got.char_count, got.last, got.end_pos,
                       got.status);
            fail_count <= fail_count + 1;
          end
        end
      end

      if (items_in.valid && items_in.ready) begin
        if (items_in.mode == MODE_DECODE)
          decode_name(items_in.start_pos, items_in.msg_len);
        else
          msg_store[items_in.load_addr] = items_in.load_byte;
      end

      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MAX_HOPS)
          hop_limit <= pwdata[7:0];
        else
          name_cap <= pwdata[7:0];
      end

      pending <= expected_chunks.size();
    end
  end

endmodule

// ===== verif/tb_dns_name_decompressor.sv =====
// Testbench top for the DNS name decompressor: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_dns_name_decompressor;
  import dnd_pkg::*;

  localparam int STORE_BYTES  = 4096;
  localparam int MSG_MAX      = 128;
  localparam int RANDOM_ITEMS = 330;
  localparam int NUM_PHASES   = 5;
  localparam int CYCLE_LIMIT  = 10_000_000;

  localparam int HOP_CFG  [NUM_PHASES] = '{255, 1, 4, 255, 2};
  localparam int CAP_CFG  [NUM_PHASES] = '{255, 1, 12, 9, 255};
  localparam int SEND_CFG [NUM_PHASES] = '{0, 88, 0, 35, 0};
  localparam int RECV_CFG [NUM_PHASES] = '{0, 0, 88, 35, 0};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  logic [7:0]  msg_buf [MSG_MAX];
  int unsigned elem_starts [$];

  dnd_in_if  item_ch ();
  dnd_out_if chunk_ch ();

  dns_name_decompressor DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (item_ch),
    .out_o   (chunk_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dnd_name_checker #(.STORE_BYTES(STORE_BYTES)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .items_in   (item_ch),
    .chunks_out (chunk_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    chunk_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic finish_item();
    int unsigned gap;
    gap = 0;
    do @(posedge clk_i); while (item_ch.ready !== 1'b1);
    items_sent++;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_load(input int unsigned addr, input int unsigned value);
    item_ch.valid <= 1'b1;
    item_ch.mode <= MODE_LOAD;
    item_ch.load_addr <= ADDR_W'(addr);
    item_ch.load_byte <= 8'(value);
    item_ch.start_pos <= ADDR_W'($urandom);
    item_ch.msg_len <= LEN_W'($urandom);
    finish_item();
  endtask

  task automatic push_decode(input int unsigned start, input int unsigned span);
    item_ch.valid <= 1'b1;
    item_ch.mode <= MODE_DECODE;
    item_ch.load_addr <= ADDR_W'($urandom);
    item_ch.load_byte <= 8'($urandom);
    item_ch.start_pos <= ADDR_W'(start);
    item_ch.msg_len <= LEN_W'(span);
    finish_item();
  endtask

  // hold the input and wait until every expected chunk has come
  task automatic wait_results();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_results();
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // labels, terminators and pointers that target element starts of this message, or at times an address past the store
  task automatic send_wellformed();
    int unsigned base, size, llen, tgt, start, span, i;
    base = $urandom_range(0, STORE_BYTES - MSG_MAX);
    size = 0;
    elem_starts.delete();
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 3)) begin
        llen = ($urandom_range(0, 24) == 0) ? 63 : $urandom_range(1, 6);
        if (size + llen + 8 <= MSG_MAX) begin
          elem_starts.push_back(size);
          msg_buf[size] = 8'(llen);
          size++;
          repeat (llen) begin
            msg_buf[size] = 8'($urandom);
            size++;
          end
        end
      end
      elem_starts.push_back(size);
      if ($urandom_range(0, 1) == 1) begin
        tgt = base + elem_starts[$urandom_range(0, elem_starts.size() - 1)];
        if ($urandom_range(0, 9) == 0) tgt = $urandom_range(STORE_BYTES, 16383);
        msg_buf[size] = {2'($urandom_range(1, 3)), 6'(tgt >> 8)};
        msg_buf[size + 1] = 8'(tgt);
        size += 2;
      end else begin
        msg_buf[size] = 8'h00;
        size++;
      end
    end
    for (i = 0; i < size; i++) push_load(base + i, msg_buf[i]);
    repeat ($urandom_range(2, 5)) begin
      start = base + elem_starts[$urandom_range(0, elem_starts.size() - 1)];
      case ($urandom_range(0, 3))
        0: span = $urandom_range(STORE_BYTES, 8191);
        1: span = $urandom_range(base + size, STORE_BYTES);
        2: span = $urandom_range(start, base + size);
        default: span = $urandom_range(0, start);
      endcase
      push_decode(start, span);
    end
  endtask

  // random bytes from offset zero, decoded only within the written bytes
  task automatic send_noise();
    int unsigned size, pick, i;
    size = $urandom_range(2, 24);
    for (i = 0; i < size; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) msg_buf[i] = 8'h00;
      else if (pick < 7) msg_buf[i] = 8'($urandom_range(1, 6));
      else msg_buf[i] = 8'($urandom);
    end
    for (i = 0; i < size; i++) push_load(i, msg_buf[i]);
    repeat ($urandom_range(2, 5))
      push_decode($urandom_range(0, size - 1), $urandom_range(0, size));
  endtask

  initial begin
    int unsigned p, random_base;
    rst_ni = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_LOAD;
    item_ch.load_addr = '0;
    item_ch.load_byte = '0;
    item_ch.start_pos = '0;
    item_ch.msg_len = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // label "ab", terminator, pointer to it, self pointer, pointer far out of range
    push_load(0, 8'h02);
    push_load(1, 8'h61);
    push_load(2, 8'h62);
    push_load(3, 8'h00);
    push_load(4, 8'h40);
    push_load(5, 8'h00);
    push_load(6, 8'hC0);
    push_load(7, 8'h06);
    push_load(8, 8'hFF);
    push_load(9, 8'hFF);
    push_load(12'hFFF, 8'hFF);
    push_decode(0, 4096);
    push_decode(3, 8191);
    push_decode(4, 6);
    push_decode(6, 8);
    push_decode(5, 5);
    push_decode(0, 2);
    push_decode(4, 5);
    push_decode(12'hFFF, 0);
    push_decode(8, 10);
    push_decode(12'hFFF, 4096);
    drain();

    random_base = items_sent;
    for (p = 0; p < NUM_PHASES; p++) begin
      apb_write(REG_MAX_HOPS, HOP_CFG[p]);
      apb_write(REG_MAX_NAME, CAP_CFG[p]);
      send_idle_pct = SEND_CFG[p];
      recv_stall_pct = RECV_CFG[p];
      while (items_sent < random_base + RANDOM_ITEMS * (p + 1) / NUM_PHASES) begin
        if ($urandom_range(0, 7) == 0) wait_results();
        if ($urandom_range(0, 3) == 0) send_noise();
        else send_wellformed();
      end
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
